/* hw/rtl/afit_pkg.sv */
// Package for the rectangle aspect fit unit: widths, payload structs, kind codes
// and small arithmetic helpers shared by all of its modules.
// Depends on nothing.
package afit_pkg;

   localparam int COORD_BITS = 16;
   localparam int CW         = COORD_BITS + 2;       // planned edge width
   localparam int SW_W       = COORD_BITS + 1;       // size (difference) width
   localparam int PW         = 2 * COORD_BITS + 2;   // cross product width
   localparam int NUM_W      = 2 * COORD_BITS;       // dividend magnitude width
   localparam int DEN_W      = COORD_BITS;           // divisor magnitude width
   localparam int QW         = NUM_W + 1;            // signed quotient width
   localparam int FW         = 2 * COORD_BITS + 4;   // final arithmetic width
   localparam int OUT_W      = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int LATENCY    = NUM_W + 5;
   localparam int CSR_AW     = 3;

   localparam logic MODE_SCALE  = 1'b0;
   localparam logic MODE_INSIDE = 1'b1;
   localparam logic REG_FIT_MODE = 1'b0;

   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;

   typedef enum logic [1:0] {KIND_POINT, KIND_HLINE, KIND_VLINE, KIND_RECT} kind_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] src_left;
      logic signed [COORD_BITS-1:0] src_top;
      logic signed [COORD_BITS-1:0] src_right;
      logic signed [COORD_BITS-1:0] src_bottom;
      logic signed [COORD_BITS-1:0] dst_left;
      logic signed [COORD_BITS-1:0] dst_top;
      logic signed [COORD_BITS-1:0] dst_right;
      logic signed [COORD_BITS-1:0] dst_bottom;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_left;
      logic signed [OUT_W-1:0] out_top;
      logic signed [OUT_W-1:0] out_right;
      logic signed [OUT_W-1:0] out_bottom;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] left;
      logic signed [CW-1:0] top;
      logic signed [CW-1:0] right;
      logic signed [CW-1:0] bottom;
   } box_type;

   // one classified item; box is the final answer, or the destination when is_lb
   typedef struct packed {
      logic                   is_lb;
      logic signed [SW_W-1:0] sw;
      logic signed [SW_W-1:0] sh;
      box_type                box;
   } plan_type;

   typedef struct packed {
      logic    is_lb;
      logic    flatter;
      logic    neg;
      box_type box;
   } ctx_type;

   typedef struct packed {
      logic [FIFO_AW:0] count;
      logic             full;
      logic             empty;
   } fifo_stat_type;

   function automatic kind_type kind_of(input logic ex, input logic ey);
      kind_type k;
      if (ex && ey) k = KIND_POINT;
      else if (ey)  k = KIND_HLINE;
      else if (ex)  k = KIND_VLINE;
      else          k = KIND_RECT;
      return k;
   endfunction

   // halve, truncating toward zero
   function automatic logic signed [FW-1:0] half_fw(input logic signed [FW-1:0] x);
      logic signed [FW-1:0] t;
      t = x + FW'({{(FW-1){1'b0}}, x[FW-1]});
      return t >>> 1;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [FW-1:0] v);
      logic signed [63:0] w;
      logic signed [OUT_W-1:0] r;
      w = 64'(v);
      if (w > I32_MAX)      r = OUT_W'(I32_MAX);
      else if (w < I32_MIN) r = OUT_W'(I32_MIN);
      else                  r = w[OUT_W-1:0];
      return r;
   endfunction

   function automatic box_type mk_box(input logic signed [CW-1:0] l, input logic signed [CW-1:0] t,
                                      input logic signed [CW-1:0] r, input logic signed [CW-1:0] b);
      box_type x;
      x.left = l; x.top = t; x.right = r; x.bottom = b;
      return x;
   endfunction

endpackage

/* hw/rtl/afit_front.sv */
// Front end of the aspect fit unit: classifies each accepted rectangle pair
// and resolves every case that needs no division. Uses afit_pkg.
module afit_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              mode,
   input  afit_pkg::req_type req,
   output logic              plan_vld,
   output afit_pkg::plan_type plan
);
   import afit_pkg::*;

   logic     vld_ff, vld_in;
   plan_type plan_ff, plan_in;

   always_comb begin
      logic signed [CW-1:0] sl, st, sr, sb, dl, dt, dr, db;
      logic signed [CW-1:0] sw, sh, dw, dh, cx, cy, ov, oh;
      kind_type ks, kd;
      box_type  dbox;
      sl = CW'(req.src_left);  st = CW'(req.src_top);
      sr = CW'(req.src_right); sb = CW'(req.src_bottom);
      dl = CW'(req.dst_left);  dt = CW'(req.dst_top);
      dr = CW'(req.dst_right); db = CW'(req.dst_bottom);
      sw = sr - sl; sh = sb - st; dw = dr - dl; dh = db - dt;
      cx = CW'(half_fw(FW'(dl + dr)));
      cy = CW'(half_fw(FW'(dt + db)));
      ov = (sh < dh) ? CW'(half_fw(FW'(dh - sh))) : '0;
      oh = (sw < dw) ? CW'(half_fw(FW'(dw - sw))) : '0;
      ks = kind_of(sl == sr, st == sb);
      kd = kind_of(dl == dr, dt == db);
      dbox = mk_box(dl, dt, dr, db);

      plan_in.is_lb = 1'b0;
      plan_in.sw    = SW_W'(sw);
      plan_in.sh    = SW_W'(sh);
      plan_in.box   = dbox;

      if (mode == MODE_SCALE) begin
         if (ks == KIND_POINT) begin
            if (kd != KIND_POINT) plan_in.box = '0;
         end else if (kd == KIND_RECT) begin
            case (ks)
               KIND_VLINE: plan_in.box = mk_box(cx, dt, cx, db);
               KIND_HLINE: plan_in.box = mk_box(dl, cy, dr, cy);
               default:    plan_in.is_lb = 1'b1;
            endcase
         end
      end else if (kd != KIND_POINT) begin
         case (ks)
            KIND_POINT: begin
               case (kd)
                  KIND_VLINE: plan_in.box = mk_box(dl, cy, dl, cy);
                  KIND_HLINE: plan_in.box = mk_box(cx, dt, cx, dt);
                  default:    plan_in.box = mk_box(cx, cy, cx, cy);
               endcase
            end
            KIND_VLINE: begin
               case (kd)
                  KIND_VLINE: plan_in.box = mk_box(dl, dt + ov, dr, db - ov);
                  KIND_HLINE: plan_in.box = mk_box(cx, dt, cx, dt);
                  default:    plan_in.box = mk_box(cx, dt + ov, cx, db - ov);
               endcase
            end
            KIND_HLINE: begin
               case (kd)
                  KIND_VLINE: plan_in.box = mk_box(dl, cy, dl, cy);
                  KIND_HLINE: plan_in.box = mk_box(dl + oh, dt, dr - oh, db);
                  default:    plan_in.box = mk_box(dl + oh, cy, dr - oh, cy);
               endcase
            end
            default: begin
               case (kd)
                  KIND_VLINE: plan_in.box = mk_box(dl, dt + ov, dr, db - ov);
                  KIND_HLINE: plan_in.box = mk_box(dl + oh, dt, dr - oh, db);
                  default: begin
                     if (sw >= dw || sh >= dh) plan_in.is_lb = 1'b1;
                     else plan_in.box = mk_box(dl + oh, dt + ov, dr - oh, db - ov);
                  end
               endcase
            end
         endcase
      end
      vld_in = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      plan_ff <= plan_in;
   end

   assign plan_vld = vld_ff;
   assign plan     = plan_ff;

endmodule

/* hw/rtl/afit_fifo.sv */
// Short queue between the front and back ends of the aspect fit unit.
// Uses afit_pkg.
module afit_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  afit_pkg::plan_type      push_data,
   input  logic                    pop,
   output afit_pkg::plan_type      head,
   output afit_pkg::fifo_stat_type stat
);
   import afit_pkg::*;

   plan_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

/* hw/rtl/afit_div.sv */
// Pipelined restoring divider of the aspect fit unit, one quotient bit per stage,
// carrying an item context alongside. Uses afit_pkg.
module afit_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  afit_pkg::ctx_type      in_ctx,
   input  logic [afit_pkg::NUM_W-1:0] in_num,
   input  logic [afit_pkg::DEN_W-1:0] in_den,
   output logic                   out_vld,
   output afit_pkg::ctx_type      out_ctx,
   output logic [afit_pkg::NUM_W-1:0] out_quo
);
   import afit_pkg::*;

   logic             vld_ff [1:NUM_W];
   ctx_type          ctx_ff [1:NUM_W];
   logic [NUM_W-1:0] nq_ff  [1:NUM_W];
   logic [DEN_W-1:0] rem_ff [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W];

   for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
      logic             p_vld;
      ctx_type          p_ctx;
      logic [NUM_W-1:0] p_nq;
      logic [DEN_W-1:0] p_rem;
      logic [DEN_W-1:0] p_den;
      logic [DEN_W:0]   trial;
      logic             ge;

      // the first stage takes the input itself
      if (k == 1) begin : g_first
         always_comb begin
            p_vld = in_vld;
            p_ctx = in_ctx;
            p_nq  = in_num;
            p_rem = '0;
            p_den = in_den;
         end
      end else begin : g_next
         always_comb begin
            p_vld = vld_ff[k-1];
            p_ctx = ctx_ff[k-1];
            p_nq  = nq_ff[k-1];
            p_rem = rem_ff[k-1];
            p_den = den_ff[k-1];
         end
      end

      always_comb begin
         trial = {p_rem, p_nq[NUM_W-1]};
         ge    = trial >= {1'b0, p_den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= p_vld;
         end
         ctx_ff[k] <= p_ctx;
         den_ff[k] <= p_den;
         nq_ff[k]  <= {p_nq[NUM_W-2:0], ge};
         rem_ff[k] <= ge ? DEN_W'(trial - {1'b0, p_den}) : DEN_W'(trial);
      end
   end

   assign out_vld = vld_ff[NUM_W];
   assign out_ctx = ctx_ff[NUM_W];
   assign out_quo = nq_ff[NUM_W];

endmodule

/* hw/rtl/afit_back.sv */
// Back end of the aspect fit unit: cross products, aspect compare, division and
// the final centring and saturation. Uses afit_pkg and afit_div.
module afit_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_vld,
   input  afit_pkg::plan_type head,
   output logic               rsp_vld,
   output afit_pkg::rsp_type  rsp
);
   import afit_pkg::*;

   // destination size of the queue head
   logic signed [CW-1:0]   h_dw, h_dh;
   // multiply stage
   logic                   m_vld_ff;
   plan_type               m_plan_ff;
   logic signed [PW-1:0]   a_ff, c_ff;
   // compare stage (divider input)
   logic                   d_vld_ff, d_vld_in;
   ctx_type                d_ctx_ff, d_ctx_in;
   logic [NUM_W-1:0]       d_num_ff, d_num_in;
   logic [DEN_W-1:0]       d_den_ff, d_den_in;
   // divider out
   logic                   q_vld;
   ctx_type                q_ctx;
   logic [NUM_W-1:0]       q_mag;
   // output stage
   logic                   o_vld_ff;
   rsp_type                o_rsp_ff, o_rsp_in;

   always_comb begin
      h_dw = head.box.right - head.box.left;
      h_dh = head.box.bottom - head.box.top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= pop_vld;
      end
      m_plan_ff <= head;
      a_ff      <= PW'(head.sh) * PW'(h_dw);
      c_ff      <= PW'(h_dh) * PW'(head.sw);
   end

   always_comb begin
      logic signed [CW-1:0]   dw;
      logic                   sw_pos, dw_pos, flatter;
      logic signed [PW-1:0]   num_s;
      logic signed [SW_W-1:0] den_s;
      dw      = m_plan_ff.box.right - m_plan_ff.box.left;
      sw_pos  = !m_plan_ff.sw[SW_W-1] && (m_plan_ff.sw != '0);
      dw_pos  = !dw[CW-1] && (dw != '0);
      flatter = (sw_pos == dw_pos) ? (a_ff < c_ff) : (a_ff > c_ff);
      num_s   = flatter ? a_ff : c_ff;
      den_s   = flatter ? m_plan_ff.sw : m_plan_ff.sh;
      d_vld_in         = m_vld_ff;
      d_ctx_in.is_lb   = m_plan_ff.is_lb;
      d_ctx_in.flatter = flatter;
      d_ctx_in.neg     = num_s[PW-1] ^ den_s[SW_W-1];
      d_ctx_in.box     = m_plan_ff.box;
      d_num_in = num_s[PW-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
      d_den_in = den_s[SW_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= d_vld_in;
      end
      d_ctx_ff <= d_ctx_in;
      d_num_ff <= d_num_in;
      d_den_ff <= d_den_in;
   end

   afit_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (d_vld_ff),
      .in_ctx  (d_ctx_ff),
      .in_num  (d_num_ff),
      .in_den  (d_den_ff),
      .out_vld (q_vld),
      .out_ctx (q_ctx),
      .out_quo (q_mag)
   );

   always_comb begin
      logic signed [QW-1:0] q_s;
      logic signed [FW-1:0] len, off, l, t, r, b;
      q_s = $signed({1'b0, q_mag});
      if (q_ctx.neg) q_s = -q_s;
      l = FW'(q_ctx.box.left);  t = FW'(q_ctx.box.top);
      r = FW'(q_ctx.box.right); b = FW'(q_ctx.box.bottom);
      len = q_ctx.flatter ? (b - t) : (r - l);
      off = half_fw(len - FW'(q_s));
      if (q_ctx.is_lb) begin
         if (q_ctx.flatter) begin
            t = t + off; b = b - off;
         end else begin
            l = l + off; r = r - off;
         end
      end
      o_rsp_in.out_left   = sat_out(l);
      o_rsp_in.out_top    = sat_out(t);
      o_rsp_in.out_right  = sat_out(r);
      o_rsp_in.out_bottom = sat_out(b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= q_vld;
      end
      o_rsp_ff <= o_rsp_in;
   end

   assign rsp_vld = o_vld_ff;
   assign rsp     = o_rsp_ff;

endmodule

/* hw/rtl/rectangle_aspect_fit_unit.sv */
// Rectangle aspect fit unit: places a source rectangle inside a destination.
// Throughput one rectangle pair per cycle while busy is low; each result is
// strobed on rsp_valid after front end, queue and back end (32-stage divider).
// Latency is fixed because the receiver cannot stall, so busy stays low in use.
// Synchronous active-high reset clears all valid flags, the queue and fit_mode.
// Uses afit_pkg, afit_front, afit_fifo and afit_back.
module rectangle_aspect_fit_unit (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  afit_pkg::req_type           req_data,
   // result channel
   output logic                        rsp_valid,
   output afit_pkg::rsp_type           rsp_data,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [afit_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import afit_pkg::*;

   logic          fit_mode_ff, fit_mode_in;
   logic          take;
   logic          plan_vld;
   plan_type      plan, head;
   fifo_stat_type fifo_stat;
   logic          pop;

   // register write: keep bit 0 only; only paddr[2] is decoded, writes with it set are ignored
   always_comb begin
      fit_mode_in = fit_mode_ff;
      if (psel && penable && pwrite && paddr[2] == REG_FIT_MODE) fit_mode_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= MODE_SCALE;
      end else begin
         fit_mode_ff <= fit_mode_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_FIT_MODE) ? {31'b0, fit_mode_ff} : '0;

   // hold off new commands once only one free queue slot is left for the item in flight
   assign busy = (fifo_stat.count >= (FIFO_AW + 1)'(FIFO_DEPTH - 1));
   assign take = start && !busy;

   afit_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .mode     (fit_mode_ff),
      .req      (req_data),
      .plan_vld (plan_vld),
      .plan     (plan)
   );

   // back end never stalls: drain one entry every cycle while the queue is not empty
   assign pop = !fifo_stat.empty;

   afit_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_vld),
      .push_data (plan),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   afit_back u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_vld (pop),
      .head    (head),
      .rsp_vld (rsp_valid),
      .rsp     (rsp_data)
   );

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(plan_vld && fifo_stat.full && !pop))
      else $error("aspect fit queue overflow");

   // every transfer in yields one result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##(LATENCY) rsp_valid)
      else $error("aspect fit result missing");

   // no result without a matching transfer in
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, LATENCY))
      else $error("aspect fit spurious result");

endmodule
